FILE: hw/rtl/stun_rap_pkg.sv
`default_nettype none

package stun_rap_pkg;

    localparam int HDR_BYTES = 20;

    localparam logic [31:0] MAGIC_COOKIE    = 32'h2112A442;
    localparam logic [15:0] TYPE_MAPPED     = 16'h0001;
    localparam logic [15:0] TYPE_XOR_MAPPED = 16'h8020;
    localparam logic [7:0]  FAMILY_IPV4     = 8'h01;
    localparam logic [7:0]  MIN_ADDR_LEN    = 8'd8;

    localparam logic CFG_TXN_ID_UPPER = 1'b0;
    localparam logic CFG_TXN_ID_LOWER = 1'b1;

    typedef enum logic [2:0] {
        STATUS_FOUND      = 3'd0,
        STATUS_NONE       = 3'd1,
        STATUS_BAD_COOKIE = 3'd2,
        STATUS_BAD_ID     = 3'd3,
        STATUS_TOO_SHORT  = 3'd4
    } status_t;

    typedef struct packed {
        logic [63:0] txn_id_upper;
        logic [31:0] txn_id_lower;
    } cfg_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] mapped_ip;
        logic [15:0] mapped_port;
        logic        was_xored;
    } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/stun_rap_parser.sv
`default_nettype none

module stun_rap_parser #(
    parameter int MAX_PAYLOAD = 256
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_fire,
    input  wire logic [7:0]            data_byte,
    input  wire logic                  last_byte,
    input  wire stun_rap_pkg::cfg_t    cfg,
    output stun_rap_pkg::result_t      result
);
    import stun_rap_pkg::*;

    localparam int IDX_W = $clog2(HDR_BYTES + MAX_PAYLOAD + 1);
    localparam int OFF_W = $clog2(MAX_PAYLOAD + 1);

    localparam int IDX_LEN_END    = 3;
    localparam int IDX_COOKIE_END = 7;
    localparam int IDX_ID0_END    = 11;
    localparam int IDX_ID1_END    = 15;
    localparam int IDX_ID2_END    = 19;

    logic [IDX_W-1:0] byte_index_reg, byte_index_next;
    logic [31:0]      header_shift_reg, header_shift_next;
    logic [15:0]      decl_len_reg, decl_len_next;
    logic             cookie_ok_reg, cookie_ok_next;
    logic             id_ok_reg, id_ok_next;
    logic [OFF_W-1:0] next_off_reg, next_off_next;
    logic [15:0]      attr_type_reg, attr_type_next;
    logic [7:0]       attr_len_reg, attr_len_next;
    logic [7:0]       family_reg, family_next;
    logic [15:0]      port_reg, port_next;
    logic [31:0]      ip_reg, ip_next;
    logic             stopped_reg, stopped_next;
    logic             found_valid_reg, found_valid_next;
    logic             found_xored_reg, found_xored_next;
    logic [15:0]      found_port_reg, found_port_next;
    logic [31:0]      found_ip_reg, found_ip_next;

    logic [OFF_W-1:0] pay_off;
    logic [OFF_W-1:0] rel;
    logic [8:0]       attr_step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_index_reg   <= '0;
            header_shift_reg <= '0;
            decl_len_reg     <= '0;
            cookie_ok_reg    <= 1'b1;
            id_ok_reg        <= 1'b1;
            next_off_reg     <= '0;
            attr_type_reg    <= '0;
            attr_len_reg     <= '0;
            family_reg       <= '0;
            port_reg         <= '0;
            ip_reg           <= '0;
            stopped_reg      <= 1'b0;
            found_valid_reg  <= 1'b0;
            found_xored_reg  <= 1'b0;
            found_port_reg   <= '0;
            found_ip_reg     <= '0;
        end else if (in_fire) begin
            byte_index_reg   <= byte_index_next;
            header_shift_reg <= header_shift_next;
            decl_len_reg     <= decl_len_next;
            cookie_ok_reg    <= cookie_ok_next;
            id_ok_reg        <= id_ok_next;
            next_off_reg     <= next_off_next;
            attr_type_reg    <= attr_type_next;
            attr_len_reg     <= attr_len_next;
            family_reg       <= family_next;
            port_reg         <= port_next;
            ip_reg           <= ip_next;
            stopped_reg      <= stopped_next;
            found_valid_reg  <= found_valid_next;
            found_xored_reg  <= found_xored_next;
            found_port_reg   <= found_port_next;
            found_ip_reg     <= found_ip_next;
        end
    end

    always_comb begin
        byte_index_next   = byte_index_reg;
        header_shift_next = header_shift_reg;
        decl_len_next     = decl_len_reg;
        cookie_ok_next    = cookie_ok_reg;
        id_ok_next        = id_ok_reg;
        next_off_next     = next_off_reg;
        attr_type_next    = attr_type_reg;
        attr_len_next     = attr_len_reg;
        family_next       = family_reg;
        port_next         = port_reg;
        ip_next           = ip_reg;
        stopped_next      = stopped_reg;
        found_valid_next  = found_valid_reg;
        found_xored_next  = found_xored_reg;
        found_port_next   = found_port_reg;
        found_ip_next     = found_ip_reg;

        pay_off   = OFF_W'(byte_index_reg - IDX_W'(HDR_BYTES));
        rel       = pay_off - next_off_reg;
        attr_step = '0;

        if (byte_index_reg < IDX_W'(HDR_BYTES + MAX_PAYLOAD)) begin
            byte_index_next = byte_index_reg + IDX_W'(1);
            if (byte_index_reg < IDX_W'(HDR_BYTES)) begin
                header_shift_next = {header_shift_reg[23:0], data_byte};
                priority if (byte_index_reg == IDX_W'(IDX_LEN_END)) begin
                    decl_len_next = header_shift_next[15:0];
                end else if (byte_index_reg == IDX_W'(IDX_COOKIE_END)) begin
                    if (header_shift_next != MAGIC_COOKIE) begin
                        cookie_ok_next = 1'b0;
                    end
                end else if (byte_index_reg == IDX_W'(IDX_ID0_END)) begin
                    if (header_shift_next != cfg.txn_id_upper[63:32]) begin
                        id_ok_next = 1'b0;
                    end
                end else if (byte_index_reg == IDX_W'(IDX_ID1_END)) begin
                    if (header_shift_next != cfg.txn_id_upper[31:0]) begin
                        id_ok_next = 1'b0;
                    end
                end else if (byte_index_reg == IDX_W'(IDX_ID2_END)) begin
                    if (header_shift_next != cfg.txn_id_lower) begin
                        id_ok_next = 1'b0;
                    end
                end else begin
                    id_ok_next = id_ok_reg;
                end
            end else if (!stopped_reg && (pay_off >= next_off_reg)) begin
                priority if (rel == OFF_W'(0)) begin
                    if (16'(pay_off) >= decl_len_reg) begin
                        stopped_next = 1'b1;
                    end else begin
                        attr_type_next = {data_byte, 8'h00};
                        family_next    = '0;
                        port_next      = '0;
                        ip_next        = '0;
                    end
                end else if (rel == OFF_W'(1)) begin
                    attr_type_next[7:0] = data_byte;
                end else if (rel == OFF_W'(2)) begin
                    if (data_byte != 8'h00) begin
                        stopped_next = 1'b1;
                    end
                end else begin
                    unique case (rel)
                        OFF_W'(3):  attr_len_next   = data_byte;
                        OFF_W'(5):  family_next     = data_byte;
                        OFF_W'(6):  port_next[15:8] = data_byte;
                        OFF_W'(7):  port_next[7:0]  = data_byte;
                        OFF_W'(8):  ip_next[31:24]  = data_byte;
                        OFF_W'(9):  ip_next[23:16]  = data_byte;
                        OFF_W'(10): ip_next[15:8]   = data_byte;
                        OFF_W'(11): ip_next[7:0]    = data_byte;
                        default:    attr_len_next   = attr_len_reg;
                    endcase
                    // Attributes are padded to a multiple of four bytes.
                    attr_step = ({1'b0, attr_len_next} + 9'd7) & ~9'd3;
                    if (16'(rel) == (16'(attr_step) - 16'd1)) begin
                        next_off_next = pay_off + OFF_W'(1);
                        if ((attr_len_next >= MIN_ADDR_LEN) && (family_next == FAMILY_IPV4)) begin
                            if (attr_type_next == TYPE_XOR_MAPPED) begin
                                found_valid_next = 1'b1;
                                found_xored_next = 1'b1;
                                found_port_next  = port_next ^ MAGIC_COOKIE[31:16];
                                found_ip_next    = ip_next ^ MAGIC_COOKIE;
                            end else if (attr_type_next == TYPE_MAPPED) begin
                                found_valid_next = 1'b1;
                                found_xored_next = 1'b0;
                                found_port_next  = port_next;
                                found_ip_next    = ip_next;
                            end
                        end
                    end
                end
            end
        end

        result.mapped_ip   = '0;
        result.mapped_port = '0;
        result.was_xored   = 1'b0;
        priority if (byte_index_next < IDX_W'(HDR_BYTES)) begin
            result.status = STATUS_TOO_SHORT;
        end else if (!cookie_ok_next) begin
            result.status = STATUS_BAD_COOKIE;
        end else if (!id_ok_next) begin
            result.status = STATUS_BAD_ID;
        end else if (found_valid_next) begin
            result.status      = STATUS_FOUND;
            result.mapped_ip   = found_ip_next;
            result.mapped_port = found_port_next;
            result.was_xored   = found_xored_next;
        end else begin
            result.status = STATUS_NONE;
        end

        if (last_byte) begin
            byte_index_next   = '0;
            header_shift_next = '0;
            decl_len_next     = '0;
            cookie_ok_next    = 1'b1;
            id_ok_next        = 1'b1;
            next_off_next     = '0;
            attr_type_next    = '0;
            attr_len_next     = '0;
            family_next       = '0;
            port_next         = '0;
            ip_next           = '0;
            stopped_next      = 1'b0;
            found_valid_next  = 1'b0;
            found_xored_next  = 1'b0;
            found_port_next   = '0;
            found_ip_next     = '0;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/stun_response_address_parser_top.sv
// STUN binding response parser.
// The slave stream carries one datagram byte per request in s_tdata, with
// s_tlast high on the final byte. The transaction id to match is written
// through the plain write port: index 0 holds its first 64 bits, index 1 its
// last 32 bits. Write them only while no datagram is in flight.
// Each byte is taken into an input register and parsed from there, so one
// byte per clock is sustained while no final byte waits on a held result;
// the per-byte parse state update is the single loop that sets this rate.
// On the final byte one result request appears on the master stream from an
// output register loaded when that byte is parsed: m_tuser gives the status
// and m_tdata the decoded IPv4 address, port and the XOR flag.
// If the receiver stalls with a result still held, bytes that do not end a
// datagram keep flowing; a final byte waits until the held result is taken.
// Reset clears the parse state and both transaction id registers, and empties
// the input and output registers.
`default_nettype none

module stun_response_address_parser_top #(
    parameter int MAX_PAYLOAD = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,     // data_byte
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,     // mapped_ip, mapped_port, was_xored, zero fill
    output logic [2:0]       m_tuser,     // status
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_addr,
    input  wire logic [63:0] cfg_wr_data
);
    import stun_rap_pkg::*;

    cfg_t    cfg_reg;
    logic    in_valid_reg;
    logic [7:0] in_data_reg;
    logic    in_last_reg;
    logic    in_fire;
    logic    out_valid_reg;
    result_t out_reg;
    result_t parse_result;

    assign in_fire  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || in_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_TXN_ID_UPPER: cfg_reg.txn_id_upper <= cfg_wr_data;
                CFG_TXN_ID_LOWER: cfg_reg.txn_id_lower <= cfg_wr_data[31:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    stun_rap_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .data_byte (in_data_reg),
        .last_byte (in_last_reg),
        .cfg       (cfg_reg),
        .result    (parse_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_fire && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire && in_last_reg) begin
            out_reg <= parse_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {7'd0, out_reg.was_xored, out_reg.mapped_port, out_reg.mapped_ip};

endmodule

`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import stun_rap_pkg::*;

    localparam int PAYLOAD_MAX = 256;
    localparam int NUM_PROBES = 20;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [15:0] atype;
        logic [15:0] alen;
        logic [7:0]  family;
        logic [15:0] port;
        logic [31:0] ip;
    } attr_spec_t;

    typedef struct packed {
        int         cut;
        bit         bad_cookie;
        bit         bad_id;
        int         decl;
        int         n_attr;
        attr_spec_t a0;
        attr_spec_t a1;
        bit         pinned;
        result_t    res;
    } probe_t;

    localparam attr_spec_t A_NONE     = '0;
    localparam attr_spec_t A_MAP_ONES = '{TYPE_MAPPED, 16'd8, FAMILY_IPV4, 16'hFFFF, 32'hFFFF_FFFF};
    localparam attr_spec_t A_MAP_ZERO = '{TYPE_MAPPED, 16'd8, FAMILY_IPV4, 16'h0000, 32'h0000_0000};
    localparam attr_spec_t A_XOR      = '{TYPE_XOR_MAPPED, 16'd8, FAMILY_IPV4, 16'h1234, 32'hC0A8_0101};
    localparam attr_spec_t A_XOR12    = '{TYPE_XOR_MAPPED, 16'd12, FAMILY_IPV4, 16'hFFFF, 32'h0};
    localparam attr_spec_t A_SHORT    = '{TYPE_MAPPED, 16'd4, FAMILY_IPV4, 16'h1234, 32'h0A00_0001};
    localparam attr_spec_t A_FAM2     = '{TYPE_XOR_MAPPED, 16'd8, 8'h02, 16'h1234, 32'h0A00_0001};
    localparam attr_spec_t A_OTHER    = '{16'h0020, 16'd8, FAMILY_IPV4, 16'h1234, 32'h0A00_0001};
    localparam attr_spec_t A_LONG     = '{TYPE_MAPPED, 16'h0108, FAMILY_IPV4, 16'h1234, 32'h1};
    localparam attr_spec_t A_PAD      = '{16'h0006, 16'd248, 8'h00, 16'h0000, 32'h0};

    localparam result_t R_SHORT  = '{STATUS_TOO_SHORT, 32'h0, 16'h0, 1'b0};
    localparam result_t R_COOKIE = '{STATUS_BAD_COOKIE, 32'h0, 16'h0, 1'b0};
    localparam result_t R_ID     = '{STATUS_BAD_ID, 32'h0, 16'h0, 1'b0};
    localparam result_t R_NONE   = '{STATUS_NONE, 32'h0, 16'h0, 1'b0};
    localparam result_t R_ONES   = '{STATUS_FOUND, 32'hFFFF_FFFF, 16'hFFFF, 1'b0};
    localparam result_t R_ZERO   = '{STATUS_FOUND, 32'h0, 16'h0, 1'b0};

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_addr = CFG_TXN_ID_UPPER;
    logic [63:0] cfg_wr_data = 64'h0;

    // Parser state as the checker sees it.
    logic [9:0]  pos;
    logic [31:0] hdr_window;
    logic [15:0] hdr_len;
    logic [1:0]  hdr_good;
    logic [9:0]  attr_start;
    logic [31:0] attr_head;
    logic [55:0] attr_body;
    logic        walk_done;
    logic [49:0] best_addr;
    logic [63:0] txn_up = 64'h0;
    logic [31:0] txn_lo = 32'h0;

    result_t     due_results[$];
    logic [7:0]  wire_q[$];
    probe_t      probes[NUM_PROBES];
    result_t     pinned;
    bit          pin_next = 1'b0;
    bit          no_idle = 1'b0;
    bit          hold_go = 1'b0;
    logic        rx_hold = 1'b0;
    int          err_count = 0;
    int          cycles = 0;
    int          bytes_sent = 0;
    int          datagrams_sent = 0;
    int          results_seen = 0;
    int          status_hits[5] = '{0, 0, 0, 0, 0};

    stun_response_address_parser_top #(
        .MAX_PAYLOAD(PAYLOAD_MAX)
    ) u_top (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr(cfg_addr),
        .cfg_wr_data(cfg_wr_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("stun_response_address_parser_top: mismatch");
            $finish;
        end
    end

    function void clear_parser();
        pos = '0;
        hdr_window = '0;
        hdr_len = '0;
        hdr_good = 2'b11;
        attr_start = '0;
        attr_head = '0;
        attr_body = '0;
        walk_done = 1'b0;
        best_addr = '0;
    endfunction

    function void parse_byte(input logic [7:0] b, input bit last, output bit emit,
                             output result_t res);
        int p;
        int rel;
        int step;
        logic [15:0] port;
        logic [31:0] ip;
        emit = 1'b0;
        res = '0;
        if (pos < HDR_BYTES + PAYLOAD_MAX) begin
            if (pos < HDR_BYTES) begin
                hdr_window = {hdr_window[23:0], b};
                case (pos)
                    3: hdr_len = hdr_window[15:0];
                    7: if (hdr_window != MAGIC_COOKIE) hdr_good[0] = 1'b0;
                    11: if (hdr_window != txn_up[63:32]) hdr_good[1] = 1'b0;
                    15: if (hdr_window != txn_up[31:0]) hdr_good[1] = 1'b0;
                    19: if (hdr_window != txn_lo) hdr_good[1] = 1'b0;
                    default: ;
                endcase
            end else begin
                p = int'(pos) - HDR_BYTES;
                if (!walk_done && p >= int'(attr_start)) begin
                    rel = p - int'(attr_start);
                    if (rel == 0) begin
                        if (p >= int'(hdr_len)) begin
                            walk_done = 1'b1;
                        end else begin
                            attr_head = {b, 24'h0};
                            attr_body = '0;
                        end
                    end else if (rel == 1) begin
                        attr_head[23:16] = b;
                    end else if (rel == 2) begin
                        if (b != 8'h00) walk_done = 1'b1;
                    end else begin
                        if (rel == 3) attr_head[7:0] = b;
                        else if (rel >= 5 && rel <= 11) attr_body[8 * (11 - rel) +: 8] = b;
                        step = (int'(attr_head[7:0]) + 7) & ~3;
                        if (rel == step - 1) begin
                            port = attr_body[47:32];
                            ip = attr_body[31:0];
                            if (attr_head[15:0] >= 16'(MIN_ADDR_LEN)
                                    && attr_body[55:48] == FAMILY_IPV4) begin
                                if (attr_head[31:16] == TYPE_XOR_MAPPED) begin
                                    best_addr = {2'b11, port ^ MAGIC_COOKIE[31:16],
                                                 ip ^ MAGIC_COOKIE};
                                end else if (attr_head[31:16] == TYPE_MAPPED) begin
                                    best_addr = {2'b10, port, ip};
                                end
                            end
                            attr_start = attr_start + 10'(step);
                        end
                    end
                end
            end
            pos = pos + 10'd1;
        end
        if (last) begin
            emit = 1'b1;
            if (pos < HDR_BYTES) begin
                res.status = STATUS_TOO_SHORT;
            end else if (!hdr_good[0]) begin
                res.status = STATUS_BAD_COOKIE;
            end else if (!hdr_good[1]) begin
                res.status = STATUS_BAD_ID;
            end else if (best_addr[49]) begin
                res.status = STATUS_FOUND;
                res.mapped_ip = best_addr[31:0];
                res.mapped_port = best_addr[47:32];
                res.was_xored = best_addr[48];
            end else begin
                res.status = STATUS_NONE;
            end
            clear_parser();
        end
    endfunction

    function probe_t mk_probe(input int cut, input bit bad_cookie, input bit bad_id,
                              input int decl, input int n_attr, input attr_spec_t a0,
                              input attr_spec_t a1, input bit pin, input result_t res);
        probe_t pr;
        pr.cut = cut;
        pr.bad_cookie = bad_cookie;
        pr.bad_id = bad_id;
        pr.decl = decl;
        pr.n_attr = n_attr;
        pr.a0 = a0;
        pr.a1 = a1;
        pr.pinned = pin;
        pr.res = res;
        return pr;
    endfunction

    task report_mismatch(input string field, input logic [63:0] got, input logic [63:0] want);
        $display("ERROR at %0t, result %0d, %s: got %0h, expected %0h",
                 $time, results_seen, field, got, want);
        err_count++;
    endtask

    task write_txn_id(input logic [63:0] up, input logic [31:0] lo);
        cfg_wr_en <= 1'b1;
        cfg_addr <= CFG_TXN_ID_UPPER;
        cfg_wr_data <= up;
        @(posedge aclk);
        cfg_addr <= CFG_TXN_ID_LOWER;
        cfg_wr_data <= {32'h0, lo};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        txn_up = up;
        txn_lo = lo;
    endtask

    task put_header(input bit bad_cookie, input bit bad_id);
        logic [31:0] cookie;
        logic [95:0] id;
        int k;
        cookie = MAGIC_COOKIE;
        id = {txn_up, txn_lo};
        if (bad_cookie) cookie ^= 32'h1 << $urandom_range(0, 31);
        if (bad_id) id ^= 96'h1 << $urandom_range(0, 95);
        wire_q.push_back(8'($urandom));
        wire_q.push_back(8'($urandom));
        wire_q.push_back(8'h00);
        wire_q.push_back(8'h00);
        for (k = 3; k >= 0; k--) wire_q.push_back(cookie[8 * k +: 8]);
        for (k = 11; k >= 0; k--) wire_q.push_back(id[8 * k +: 8]);
    endtask

    task put_attr(input attr_spec_t a);
        logic [63:0] body;
        int padded;
        int k;
        wire_q.push_back(a.atype[15:8]);
        wire_q.push_back(a.atype[7:0]);
        wire_q.push_back(a.alen[15:8]);
        wire_q.push_back(a.alen[7:0]);
        if (a.alen[15:8] != 8'h00) begin
            repeat (4) wire_q.push_back(8'($urandom));
        end else begin
            body = {8'($urandom), a.family, a.port, a.ip};
            padded = (int'(a.alen) + 3) & ~3;
            for (k = 0; k < padded; k++) begin
                wire_q.push_back(k < 8 ? body[63 - 8 * k -: 8] : 8'($urandom));
            end
        end
    endtask

    // A negative length means the true payload length; a cut keeps that many bytes.
    task seal(input int decl, input int cut);
        int plen;
        plen = (decl < 0) ? wire_q.size() - HDR_BYTES : decl;
        wire_q[2] = 8'(plen >> 8);
        wire_q[3] = 8'(plen);
        if (cut > 0 && cut < wire_q.size()) wire_q = wire_q[0:cut - 1];
    endtask

    task send_byte(input logic [7:0] b, input bit last);
        int gap;
        bit emit;
        result_t res;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
        parse_byte(b, last, emit, res);
        if (emit) begin
            if (pin_next) begin
                res = pinned;
                pin_next = 1'b0;
            end
            due_results.push_back(res);
            status_hits[res.status]++;
            datagrams_sent++;
        end
    endtask

    task send_datagram();
        int k;
        for (k = 0; k < wire_q.size(); k++) send_byte(wire_q[k], k == wire_q.size() - 1);
    endtask

    task send_random_datagram();
        int r;
        int t;
        int n;
        int decl;
        int cut;
        attr_spec_t a;
        wire_q.delete();
        r = $urandom_range(0, 99);
        if (r < 6) begin
            n = $urandom_range(1, 40);
            repeat (n) wire_q.push_back(8'($urandom));
        end else begin
            put_header(r >= 6 && r < 12, r >= 12 && r < 18);
            if (r >= 18 && r < 21) begin
                put_attr('{16'($urandom), 16'($urandom_range(200, 252)), 8'($urandom),
                           16'h0, 32'h0});
            end
            n = $urandom_range(0, 3);
            repeat (n) begin
                t = $urandom_range(0, 9);
                a.atype = (t < 4) ? TYPE_MAPPED : (t < 8) ? TYPE_XOR_MAPPED : 16'($urandom);
                t = $urandom_range(0, 99);
                a.alen = (t < 70) ? 16'd8 :
                         (t < 80) ? 16'($urandom_range(0, 7)) :
                         (t < 95) ? 16'($urandom_range(9, 24)) :
                                    16'($urandom_range(256, 65535));
                a.family = ($urandom_range(0, 9) == 0) ? 8'($urandom) : FAMILY_IPV4;
                a.port = 16'($urandom);
                a.ip = $urandom;
                put_attr(a);
            end
            t = $urandom_range(0, 99);
            decl = (t < 85) ? -1 : (t < 95) ? $urandom_range(0, 80) : $urandom_range(0, 65535);
            cut = ($urandom_range(0, 99) < 10) ? $urandom_range(1, wire_q.size()) : -1;
            seal(decl, cut);
        end
        send_datagram();
    endtask

    task drain();
        s_tvalid <= 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // The long receiver stall runs on its own so that the sender keeps pushing.
    initial begin
        wait (hold_go);
        @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    initial begin
        int w;
        result_t want;
        wait (aresetn);
        forever begin
            w = no_idle ? 0 : $urandom_range(0, 7);
            if (w > 0 || rx_hold) begin
                m_tready <= 1'b0;
                repeat (w) @(posedge aclk);
                while (rx_hold) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) begin
                if (rx_hold) begin
                    m_tready <= 1'b0;
                    while (rx_hold) @(posedge aclk);
                    m_tready <= 1'b1;
                end
                @(posedge aclk);
            end
            results_seen++;
            if (due_results.size() == 0) begin
                report_mismatch("result with none due", 64'(m_tuser), 64'h0);
            end else begin
                want = due_results.pop_front();
                if (m_tuser !== want.status)
                    report_mismatch("status", 64'(m_tuser), 64'(want.status));
                if (m_tdata[31:0] !== want.mapped_ip)
                    report_mismatch("mapped_ip", 64'(m_tdata[31:0]), 64'(want.mapped_ip));
                if (m_tdata[47:32] !== want.mapped_port)
                    report_mismatch("mapped_port", 64'(m_tdata[47:32]),
                                    64'(want.mapped_port));
                if (m_tdata[48] !== want.was_xored)
                    report_mismatch("was_xored", 64'(m_tdata[48]), 64'(want.was_xored));
            end
        end
    end

    initial begin
        int i;
        int ph;
        int bytes_goal;
        int dgram_goal;
        logic [63:0] up;
        logic [31:0] lo;
        probes[0]  = mk_probe(1, 0, 0, -1, 0, A_NONE, A_NONE, 1, R_SHORT);
        probes[1]  = mk_probe(19, 0, 0, -1, 0, A_NONE, A_NONE, 1, R_SHORT);
        probes[2]  = mk_probe(-1, 1, 0, -1, 0, A_NONE, A_NONE, 1, R_COOKIE);
        probes[3]  = mk_probe(-1, 1, 1, -1, 1, A_MAP_ONES, A_NONE, 1, R_COOKIE);
        probes[4]  = mk_probe(-1, 0, 1, -1, 1, A_MAP_ONES, A_NONE, 1, R_ID);
        probes[5]  = mk_probe(-1, 0, 0, -1, 0, A_NONE, A_NONE, 1, R_NONE);
        probes[6]  = mk_probe(-1, 0, 0, -1, 1, A_MAP_ONES, A_NONE, 1, R_ONES);
        probes[7]  = mk_probe(-1, 0, 0, -1, 1, A_MAP_ZERO, A_NONE, 1, R_ZERO);
        probes[8]  = mk_probe(-1, 0, 0, -1, 1, A_XOR, A_NONE, 0, R_NONE);
        probes[9]  = mk_probe(-1, 0, 0, -1, 2, A_MAP_ONES, A_XOR, 0, R_NONE);
        probes[10] = mk_probe(-1, 0, 0, -1, 2, A_XOR, A_MAP_ZERO, 1, R_ZERO);
        probes[11] = mk_probe(-1, 0, 0, -1, 1, A_SHORT, A_NONE, 1, R_NONE);
        probes[12] = mk_probe(-1, 0, 0, -1, 1, A_FAM2, A_NONE, 1, R_NONE);
        probes[13] = mk_probe(-1, 0, 0, -1, 1, A_OTHER, A_NONE, 1, R_NONE);
        probes[14] = mk_probe(-1, 0, 0, -1, 2, A_LONG, A_MAP_ONES, 1, R_NONE);
        probes[15] = mk_probe(-1, 0, 0, 0, 1, A_MAP_ONES, A_NONE, 1, R_NONE);
        probes[16] = mk_probe(-1, 0, 0, 4, 2, A_MAP_ONES, A_XOR, 0, R_NONE);
        probes[17] = mk_probe(28, 0, 0, -1, 1, A_MAP_ONES, A_NONE, 1, R_NONE);
        probes[18] = mk_probe(-1, 0, 0, -1, 2, A_PAD, A_MAP_ONES, 0, R_NONE);
        probes[19] = mk_probe(-1, 0, 0, -1, 1, A_XOR12, A_NONE, 0, R_NONE);
        clear_parser();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_txn_id(64'h0123_4567_89AB_CDEF, 32'h0BAD_F00D);
        for (i = 0; i < NUM_PROBES; i++) begin
            wire_q.delete();
            put_header(probes[i].bad_cookie, probes[i].bad_id);
            if (probes[i].n_attr > 0) put_attr(probes[i].a0);
            if (probes[i].n_attr > 1) put_attr(probes[i].a1);
            seal(probes[i].decl, probes[i].cut);
            pin_next = probes[i].pinned;
            pinned = probes[i].res;
            send_datagram();
        end
        drain();
        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    up = '1;
                    lo = '1;
                end
                1: begin
                    up = '0;
                    lo = '0;
                end
                default: begin
                    up = {$urandom, $urandom};
                    lo = $urandom;
                end
            endcase
            write_txn_id(up, lo);
            no_idle = (ph == 2);
            if (ph == 2) hold_go = 1'b1;
            bytes_goal = bytes_sent + 80;
            dgram_goal = datagrams_sent + 2;
            while (bytes_sent < bytes_goal || datagrams_sent < dgram_goal) send_random_datagram();
            drain();
        end
        repeat (16) @(posedge aclk);
        $display("Sent %0d bytes in %0d datagrams over 5 transaction id settings,",
                 bytes_sent, datagrams_sent);
        $display("with one long receiver stall.");
        $display("Results: %0d found, %0d none, %0d bad cookie, %0d bad id, %0d too short.",
                 status_hits[0], status_hits[1], status_hits[2], status_hits[3], status_hits[4]);
        if (err_count == 0) begin
            $display("stun_response_address_parser_top: match");
        end else begin
            $display("stun_response_address_parser_top: mismatch");
        end
        $finish;
    end

endmodule

FILE: stun_response_address_parser_top.f
hw/rtl/stun_rap_pkg.sv
hw/rtl/stun_rap_parser.sv
hw/rtl/stun_response_address_parser_top.sv
bench/testbench.sv
